// File: hw/rtl/ctu_pkg.sv
// shared types for the clipmap toroidal update block
`default_nettype none
package ctu_pkg;

    typedef struct packed {
        logic [2:0]         level_index;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
    } t_in;

    typedef struct packed {
        logic [7:0]         tile_col;
        logic [7:0]         tile_row;
        logic [8:0]         span_w;
        logic [8:0]         span_h;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [2:0]         region_level;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [2:0]         lvl;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic               full;
        logic               dx_neg;
        logic               dy_neg;
    } t_job;

    localparam int unsigned SLOTS = 8;

endpackage
`default_nettype wire

// File: hw/rtl/ctu_front.sv
// front end: level state, origin compare and job classification
`default_nettype none
module ctu_front #(
    parameter int LEVEL_SIZE  = 256,
    parameter int LEVEL_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire ctu_pkg::t_in i_in_data,
    output logic             o_in_stall,
    input  wire logic        i_q_full,
    output logic             o_push,
    output ctu_pkg::t_job    o_job
);
    import ctu_pkg::*;

    localparam int LVW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam logic signed [32:0] S33 = 33'(LEVEL_SIZE);

    logic signed [31:0] r_wx [LEVEL_COUNT];
    logic signed [31:0] r_wy [LEVEL_COUNT];
    logic [LEVEL_COUNT-1:0] r_need;

    logic [LVW-1:0] idx;
    logic in_range, acc, changed, big;
    logic signed [31:0] sx, sy, ox, oy;
    logic signed [32:0] dx, dy;

    assign o_in_stall = i_q_full;
    assign acc = i_in_valid && !i_q_full;
    assign in_range = 32'(i_in_data.level_index) < LEVEL_COUNT;
    assign idx = LVW'(i_in_data.level_index);

    always_comb begin
        sx = i_in_data.offset_x >>> i_in_data.level_index;
        sy = i_in_data.offset_y >>> i_in_data.level_index;
        ox = r_wx[idx];
        oy = r_wy[idx];
        dx = {sx[31], sx} - {ox[31], ox};
        dy = {sy[31], sy} - {oy[31], oy};
        big = (dx >= S33) || (dx <= -S33) || (dy >= S33) || (dy <= -S33);
        changed = (sx != ox) || (sy != oy) || r_need[idx];
        o_push = acc && in_range && changed;
        o_job.lvl    = i_in_data.level_index;
        o_job.sx     = sx;
        o_job.sy     = sy;
        o_job.ox     = ox;
        o_job.oy     = oy;
        o_job.full   = big || r_need[idx];
        o_job.dx_neg = dx[32];
        o_job.dy_neg = dy[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= '1;
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_wx[i] <= '0;
                r_wy[i] <= '0;
            end
        end else if (acc && in_range) begin
            r_wx[idx]   <= sx;
            r_wy[idx]   <= sy;
            r_need[idx] <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ctu_queue.sv
// two-entry job queue between front and back
`default_nettype none
module ctu_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ctu_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output ctu_pkg::t_job      o_head
);
    import ctu_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp <= !r_wp;
            end
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ctu_back.sv
// back end: builds the refresh rectangles of one job and emits one per cycle while the output is not stalled
`default_nettype none
module ctu_back #(
    parameter int LEVEL_SIZE = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire ctu_pkg::t_job i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output ctu_pkg::t_out      o_out_data,
    input  wire logic          i_out_stall
);
    import ctu_pkg::*;

    localparam int LG = $clog2(LEVEL_SIZE);
    localparam logic [31:0] S32  = 32'(LEVEL_SIZE);
    localparam logic [31:0] MSK  = 32'(LEVEL_SIZE - 1);
    localparam logic [LG:0] SLG  = (LG + 1)'(LEVEL_SIZE);

    typedef struct packed {
        logic [LG-1:0] tx;
        logic [LG-1:0] ty;
        logic [LG:0]   sw;
        logic [LG:0]   sh;
        logic [31:0]   ox;
        logic [31:0]   oy;
    } t_cand;

    function automatic t_cand mk(input logic [LG-1:0] tx, input logic [LG-1:0] ty,
                                 input logic [LG:0] sw, input logic [LG:0] sh,
                                 input logic [31:0] ox, input logic [31:0] oy);
        t_cand c;
        c.tx = tx; c.ty = ty; c.sw = sw; c.sh = sh; c.ox = ox; c.oy = oy;
        return c;
    endfunction

    t_job        r_job;
    logic        r_busy;
    logic [7:0]  r_done;
    logic        r_ov;
    t_out        r_out;

    t_cand       cand [SLOTS];
    logic [7:0]  mask, pend, rest;
    logic [2:0]  sel;
    logic [LG-1:0] wx, wy, owx, owy, z;
    logic [LG:0] cwx, cwy, cowx, cowy, adx, ady, z1;
    logic        wdx_neg, wdy_neg;
    logic [31:0] sx, sy, ox, oy, bx, by, oby, bxs, bys, obys, oxs, oys, bxo, byo;
    logic        out_free, emit;

    always_comb begin
        z  = '0;
        z1 = '0;
        sx = r_job.sx; sy = r_job.sy; ox = r_job.ox; oy = r_job.oy;
        wx = sx[LG-1:0]; wy = sy[LG-1:0];
        owx = ox[LG-1:0]; owy = oy[LG-1:0];
        bx = sx & ~MSK; by = sy & ~MSK; oby = oy & ~MSK;
        bxs = bx + S32; bys = by + S32; obys = oby + S32;
        oxs = ox + S32; oys = oy + S32;
        bxo = bx + 32'(owx); byo = by + 32'(owy);
        cwx = SLG - (LG + 1)'(wx); cwy = SLG - (LG + 1)'(wy);
        cowx = SLG - (LG + 1)'(owx); cowy = SLG - (LG + 1)'(owy);
        wdx_neg = wx < owx; wdy_neg = wy < owy;
        adx = wdx_neg ? (LG + 1)'(owx - wx) : (LG + 1)'(wx - owx);
        ady = wdy_neg ? (LG + 1)'(owy - wy) : (LG + 1)'(wy - owy);
        for (int k = 0; k < SLOTS; k++) cand[k] = mk(z, z, z1, z1, '0, '0);
        if (r_job.full) begin
            cand[0] = mk(z, z, (LG + 1)'(wx), (LG + 1)'(wy), bxs, bys);
            cand[1] = mk(wx, z, cwx, (LG + 1)'(wy), sx, bys);
            cand[2] = mk(z, wy, (LG + 1)'(wx), cwy, bxs, sy);
            cand[3] = mk(wx, wy, cwx, cwy, sx, sy);
        end else begin
            unique case ({wdx_neg, r_job.dx_neg})
                2'b00: begin
                    cand[0] = mk(owx, z, adx, (LG + 1)'(owy), oxs, obys);
                    cand[1] = mk(owx, owy, adx, cowy, oxs, oy);
                end
                2'b11: begin
                    cand[0] = mk(wx, z, adx, (LG + 1)'(owy), sx, obys);
                    cand[1] = mk(wx, owy, adx, cowy, sx, oy);
                end
                2'b10: begin
                    cand[0] = mk(z, z, (LG + 1)'(wx), (LG + 1)'(owy), bxs, obys);
                    cand[1] = mk(owx, z, cowx, (LG + 1)'(owy), bxo, obys);
                    cand[2] = mk(z, owy, (LG + 1)'(wx), cowy, bxs, oy);
                    cand[3] = mk(owx, owy, cowx, cowy, bxo, oy);
                end
                default: begin
                    cand[0] = mk(z, z, (LG + 1)'(owx), (LG + 1)'(owy), bxs, obys);
                    cand[1] = mk(wx, z, cwx, (LG + 1)'(owy), sx, obys);
                    cand[2] = mk(z, owy, (LG + 1)'(owx), cowy, bxs, oy);
                    cand[3] = mk(wx, owy, cwx, cowy, sx, oy);
                end
            endcase
            unique case ({wdy_neg, r_job.dy_neg})
                2'b00: begin
                    cand[4] = mk(z, owy, (LG + 1)'(wx), ady, bxs, oys);
                    cand[5] = mk(wx, owy, cwx, ady, sx, oys);
                end
                2'b11: begin
                    cand[4] = mk(z, wy, (LG + 1)'(wx), ady, bxs, sy);
                    cand[5] = mk(wx, wy, cwx, ady, sx, sy);
                end
                2'b10: begin
                    cand[4] = mk(z, z, (LG + 1)'(wx), (LG + 1)'(wy), bxs, bys);
                    cand[5] = mk(z, owy, (LG + 1)'(wx), cowy, bxs, byo);
                    cand[6] = mk(wx, z, cwx, (LG + 1)'(wy), sx, bys);
                    cand[7] = mk(wx, owy, cwx, cowy, sx, byo);
                end
                default: begin
                    cand[4] = mk(z, z, (LG + 1)'(wx), (LG + 1)'(owy), bxs, bys);
                    cand[5] = mk(z, wy, (LG + 1)'(wx), cwy, bxs, sy);
                    cand[6] = mk(wx, z, cwx, (LG + 1)'(owy), sx, bys);
                    cand[7] = mk(wx, wy, cwx, cwy, sx, sy);
                end
            endcase
        end
        for (int k = 0; k < SLOTS; k++) mask[k] = (cand[k].sw != '0) && (cand[k].sh != '0);
        pend = mask & ~r_done;
        sel = 3'd0;
        for (int k = SLOTS - 1; k >= 0; k--) if (pend[k]) sel = 3'(k);
        rest = pend & ~(8'd1 << sel);
    end

    assign out_free = !r_ov || !i_out_stall;
    assign emit = r_busy && out_free && (pend != '0);
    assign o_pop = !r_busy && !i_q_empty;
    assign o_out_valid = r_ov;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_done <= '0;
        end else begin
            if (o_pop) begin
                r_job  <= i_head;
                r_done <= '0;
                r_busy <= 1'b1;
            end else if (r_busy && pend == '0) begin
                // job produced no rectangle
                r_busy <= 1'b0;
            end else if (emit) begin
                r_done[sel] <= 1'b1;
                if (rest == '0) r_busy <= 1'b0;
            end
            if (out_free) begin
                r_ov <= emit;
                r_out.tile_col     <= 8'(cand[sel].tx);
                r_out.tile_row     <= 8'(cand[sel].ty);
                r_out.span_w       <= 9'(cand[sel].sw);
                r_out.span_h       <= 9'(cand[sel].sh);
                r_out.origin_x     <= cand[sel].ox;
                r_out.origin_y     <= cand[sel].oy;
                r_out.region_level <= r_job.lvl;
                r_out.last         <= rest == '0;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/clipmap_toroidal_update_regions.sv
// path: an accepted request is written into the job queue, then popped into the back-end
// job register, and its rectangles are registered at the output; throughput: one rectangle
// per cycle while the output is not stalled, with the next request loaded into the back end
// between jobs; the front takes one per cycle until the two-entry job queue fills
// reset: every level origin is zero and every level is marked for full refresh
`default_nettype none
module clipmap_toroidal_update_regions #(
    parameter int LEVEL_SIZE  = 256,
    parameter int LEVEL_COUNT = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire ctu_pkg::t_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ctu_pkg::t_out      o_out_data,
    input  wire logic          i_out_stall
);
    import ctu_pkg::*;

    logic q_full, q_empty, push, pop;
    t_job job, head;

    ctu_front #(.LEVEL_SIZE(LEVEL_SIZE), .LEVEL_COUNT(LEVEL_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_data, .o_in_stall,
        .i_q_full(q_full), .o_push(push), .o_job(job)
    );

    ctu_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job), .o_full(q_full),
        .i_pop(pop), .o_empty(q_empty), .o_head(head)
    );

    ctu_back #(.LEVEL_SIZE(LEVEL_SIZE)) u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_head(head), .o_pop(pop),
        .o_out_valid, .o_out_data, .i_out_stall
    );

endmodule
`default_nettype wire
